FILE: hw/rtl/ccki_pkg.sv
`timescale 1ns / 1ps

package ccki_pkg;

    // defaults for the top level parameters
    localparam int MAX_KEYS_DEF       = 16;
    localparam int TIME_FRAC_BITS_DEF = 4;

    // fixed field geometry
    localparam int DAY_UNITS = 2880;     // half-minute units per day
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int KTIME_W   = 12;
    localparam int COLOR_W   = 24;
    localparam int STIME_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int OCHAN_W   = 2 * CHAN_W;

    typedef struct packed {
        logic                 mode;
        logic [INDEX_W-1:0]   key_index;
        logic [KTIME_W-1:0]   key_time;
        logic [COLOR_W-1:0]   key_color;
        logic [STIME_W-1:0]   sample_time;
    } in_item_t;

    typedef struct packed {
        logic [OCHAN_W-1:0]   red;
        logic [OCHAN_W-1:0]   green;
        logic [OCHAN_W-1:0]   blue;
        logic [INDEX_W-1:0]   first_key;
        logic [FRAC_W-1:0]    fraction;
    } out_item_t;

    // control for the bit-serial units
    typedef struct packed {
        logic load;
        logic step;
    } ser_ctrl_t;

endpackage

FILE: hw/rtl/cyclic_color_keyframe_interp.sv
// Write request: taken while idle, no result.
// Sample request: n keys in use; one sample at a time, requests stall until the result
//   is handed to the output register; with fewer than two keys the key scan is skipped.
// The work is the key scan (one time-memory read per cycle) plus the 16-step serial divider.
// Reset (rst_n low, async) clears key_count and all handshake state; key memories
// are not cleared and hold garbage until written.
`timescale 1ns / 1ps

module cyclic_color_keyframe_interp #(
    parameter int MAX_KEYS       = ccki_pkg::MAX_KEYS_DEF,
    parameter int TIME_FRAC_BITS = ccki_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ccki_pkg::in_item_t            in_data,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output ccki_pkg::out_item_t           out_data,
    // key_count register
    input  logic                          cfg_we,
    input  logic [ccki_pkg::COUNT_W-1:0]  cfg_wdata
);

    // memory address width, and width able to hold the key count itself
    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    // time arithmetic width: shifted key time or sample time, plus one day, plus slack
    localparam int KSH = ccki_pkg::KTIME_W + TIME_FRAC_BITS;
    localparam int TW  = ((KSH > ccki_pkg::STIME_W) ? KSH : ccki_pkg::STIME_W) + 2;
    localparam logic [TW-1:0] DAY_W = TW'(ccki_pkg::DAY_UNITS << TIME_FRAC_BITS);
    // divider step counter: FRAC_W divider steps plus one lagging blend step
    localparam int BW = $clog2(ccki_pkg::FRAC_W + 1);
    localparam logic [BW-1:0] LAST_STEP = BW'(ccki_pkg::FRAC_W);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,   // waiting for a request
        ST_SCAN = 8'b0000_0010,   // streaming key times, testing segment k-1..k
        ST_WRAP = 8'b0000_0100,   // test the segment that wraps past midnight
        ST_COLA = 8'b0000_1000,   // read color of first key
        ST_COLZ = 8'b0001_0000,   // read color of second key
        ST_COLW = 8'b0010_0000,   // load divider and blend units
        ST_DIV  = 8'b0100_0000,   // serial divide and blend, bit per cycle
        ST_DONE = 8'b1000_0000    // hand the result to the output register
    } state_t;

    state_t                         state_reg, state_next;
    logic [ccki_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [NW-1:0]                  iss_reg, iss_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [BW-1:0]                  bit_cnt_reg, bit_cnt_next;
    logic                           out_valid_reg, out_valid_next;

    // payload, no reset
    logic [ccki_pkg::STIME_W-1:0]   sample_reg, sample_next;
    logic [ccki_pkg::KTIME_W-1:0]   prev_reg, prev_next;
    logic [ccki_pkg::KTIME_W-1:0]   t0_reg, t0_next;
    logic [AW-1:0]                  a_reg, a_next;
    logic [AW-1:0]                  z_reg, z_next;
    logic [TW-1:0]                  rem_reg, rem_next;
    logic [TW-1:0]                  den_reg, den_next;
    logic                           zero_reg, zero_next;
    logic [ccki_pkg::COLOR_W-1:0]   ca_reg, ca_next;
    ccki_pkg::out_item_t            out_data_reg, out_data_next;

    // memory ports
    logic                           key_we;
    logic [AW-1:0]                  key_waddr;
    logic [AW-1:0]                  time_raddr;
    logic [AW-1:0]                  color_raddr;
    logic [ccki_pkg::KTIME_W-1:0]   time_rdata;
    logic [ccki_pkg::COLOR_W-1:0]   color_rdata;
    logic [31:0]                    widx;

    // serial units
    ccki_pkg::ser_ctrl_t            div_ctrl, blend_ctrl;
    logic                           qbit;
    logic [ccki_pkg::FRAC_W-1:0]    quot;
    logic [ccki_pkg::OCHAN_W-1:0]   red_w, green_w, blue_w;

    // keys in use, saturated to the memory depth
    logic [NW-1:0]                  n_w;
    logic                           in_acc;
    logic                           out_free;
    logic [31:0]                    a_wide;

    // segment tests
    logic [TW-1:0]                  at_s, start_s, end_s;
    logic                           hit_s, last_s;
    logic [TW-1:0]                  start_w, end_w, at_w;
    logic                           hit_w;

    assign n_w = (32'(count_reg) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(count_reg);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // key writes go straight to both memories; slots past the depth are dropped
    assign widx      = 32'(in_data.key_index);
    assign key_waddr = widx[AW-1:0];
    assign key_we    = in_acc && !in_data.mode && (widx < 32'(MAX_KEYS));

    assign time_raddr  = iss_reg[AW-1:0];
    assign color_raddr = (state_reg == ST_COLA) ? a_reg : z_reg;

    // interior segment: start is the previous key, end is the key just read
    always_comb
    begin
        at_s    = TW'(sample_reg);
        start_s = TW'(prev_reg) << TIME_FRAC_BITS;
        end_s   = TW'(time_rdata) << TIME_FRAC_BITS;
        hit_s   = rd_vld_reg && (rd_idx_reg != '0) && (at_s >= start_s) && (at_s < end_s);
        last_s  = rd_vld_reg && (32'(rd_idx_reg) == 32'(n_w) - 32'd1);
    end

    // wrapping segment: end is key 0 one day later, early samples move a day later
    always_comb
    begin
        start_w = TW'(prev_reg) << TIME_FRAC_BITS;
        end_w   = (TW'(t0_reg) << TIME_FRAC_BITS) + DAY_W;
        at_w    = (at_s < start_w) ? at_s + DAY_W : at_s;
        hit_w   = (at_w >= start_w) && (at_w < end_w);
    end

    always_comb
    begin
        div_ctrl.load   = (state_reg == ST_COLW);
        div_ctrl.step   = (state_reg == ST_DIV) && (bit_cnt_reg != LAST_STEP);
        // blend consumes the registered quotient bit in the cycle after the divider makes it
        blend_ctrl.load = (state_reg == ST_COLW);
        blend_ctrl.step = (state_reg == ST_DIV) && (bit_cnt_reg != '0);
    end

    assign a_wide = 32'(a_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        prev_next      = prev_reg;
        t0_next        = t0_reg;
        a_next         = a_reg;
        z_next         = z_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        zero_next      = zero_reg;
        ca_next        = ca_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.mode)
                begin
                    sample_next = in_data.sample_time;
                    zero_next   = (n_w == '0);
                    // default segment: key 0 unblended
                    a_next      = '0;
                    z_next      = '0;
                    rem_next    = '0;
                    den_next    = TW'(1);
                    iss_next    = '0;
                    if (32'(n_w) < 32'd2)
                    begin
                        state_next = ST_COLA;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next key time read
                if (iss_reg < n_w)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + NW'(1);
                end
                if (rd_vld_reg)
                begin
                    prev_next = time_rdata;
                    if (rd_idx_reg == '0)
                    begin
                        t0_next = time_rdata;
                    end
                end
                if (hit_s)
                begin
                    a_next      = rd_idx_reg - AW'(1);
                    z_next      = rd_idx_reg;
                    rem_next    = at_s - start_s;
                    den_next    = end_s - start_s;
                    rd_vld_next = 1'b0;
                    state_next  = ST_COLA;
                end
                else if (last_s)
                begin
                    rd_vld_next = 1'b0;
                    state_next  = ST_WRAP;
                end
            end

            ST_WRAP:
            begin
                if (hit_w)
                begin
                    a_next   = AW'(32'(n_w) - 32'd1);
                    z_next   = '0;
                    rem_next = at_w - start_w;
                    den_next = end_w - start_w;
                end
                state_next = ST_COLA;
            end

            ST_COLA:
            begin
                state_next = ST_COLZ;
            end

            ST_COLZ:
            begin
                ca_next    = color_rdata;
                state_next = ST_COLW;
            end

            ST_COLW:
            begin
                bit_cnt_next = '0;
                state_next   = ST_DIV;
            end

            ST_DIV:
            begin
                bit_cnt_next = bit_cnt_reg + BW'(1);
                if (bit_cnt_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next.red       = red_w;
                        out_data_next.green     = green_w;
                        out_data_next.blue      = blue_w;
                        out_data_next.first_key = a_wide[ccki_pkg::INDEX_W-1:0];
                        out_data_next.fraction  = quot;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        prev_reg     <= prev_next;
        t0_reg       <= t0_next;
        a_reg        <= a_next;
        z_reg        <= z_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        zero_reg     <= zero_next;
        ca_reg       <= ca_next;
        out_data_reg <= out_data_next;
    end

    ccki_ram #(
        .WIDTH (ccki_pkg::KTIME_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (in_data.key_time),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    ccki_ram #(
        .WIDTH (ccki_pkg::COLOR_W),
        .DEPTH (MAX_KEYS)
    ) u_color_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (in_data.key_color),
        .raddr (color_raddr),
        .rdata (color_rdata)
    );

    ccki_div #(
        .TW (TW)
    ) u_div (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (rem_reg),
        .den  (den_reg),
        .qbit (qbit),
        .quot (quot)
    );

    ccki_blend u_blend (
        .clk     (clk),
        .ctrl    (blend_ctrl),
        .color_a (ca_reg),
        .color_z (color_rdata),
        .qbit    (qbit),
        .red     (red_w),
        .green   (green_w),
        .blue    (blue_w)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // divider operands: offset always below the segment length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLA) |-> (rem_reg < den_reg))
        else $error("segment offset not below segment length");

    // sample request starts a scan or goes straight to the color reads
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.mode) |=>
        (state_reg == ST_SCAN || state_reg == ST_COLA))
        else $error("sample request not started");

    // step counter stays within the divide window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (bit_cnt_reg <= LAST_STEP))
        else $error("serial step counter overran");
`endif

endmodule

FILE: hw/rtl/ccki_ram.sv
`timescale 1ns / 1ps

module ccki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ccki_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per step, MSB first.
// Expects num < den, so the quotient fits in FRAC_W bits.
module ccki_div #(
    parameter int TW = 18
) (
    input  logic                       clk,
    input  ccki_pkg::ser_ctrl_t        ctrl,
    input  logic [TW-1:0]              num,
    input  logic [TW-1:0]              den,
    output logic                       qbit,
    output logic [ccki_pkg::FRAC_W-1:0] quot
);

    logic [TW-1:0]                 r_reg, r_next;
    logic [TW-1:0]                 d_reg;
    logic [ccki_pkg::FRAC_W-1:0]   q_reg, q_next;
    logic [TW:0]                   shifted;
    logic                          fits;

    always_comb
    begin
        shifted = {r_reg, 1'b0};
        fits    = (shifted >= {1'b0, d_reg});
        r_next  = r_reg;
        q_next  = q_reg;
        if (ctrl.step)
        begin
            if (fits)
            begin
                r_next = TW'(shifted - {1'b0, d_reg});
            end
            else
            begin
                r_next = shifted[TW-1:0];
            end
            q_next = {q_reg[ccki_pkg::FRAC_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            r_reg <= num;
            d_reg <= den;
            q_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign qbit = q_reg[0];
    assign quot = q_reg;

endmodule

FILE: hw/rtl/ccki_blend.sv
`timescale 1ns / 1ps

// Three bit-serial multipliers: acc = (y - x) * frac, frac fed MSB first.
// Channel out = x*256 + floor(acc / 256), kept to 16 bits.
module ccki_blend (
    input  logic                          clk,
    input  ccki_pkg::ser_ctrl_t           ctrl,
    input  logic [ccki_pkg::COLOR_W-1:0]  color_a,
    input  logic [ccki_pkg::COLOR_W-1:0]  color_z,
    input  logic                          qbit,
    output logic [ccki_pkg::OCHAN_W-1:0]  red,
    output logic [ccki_pkg::OCHAN_W-1:0]  green,
    output logic [ccki_pkg::OCHAN_W-1:0]  blue
);

    localparam int CW    = ccki_pkg::CHAN_W;
    localparam int ACC_W = CW + 1 + ccki_pkg::FRAC_W;
    localparam int NCH   = ccki_pkg::COLOR_W / CW;

    logic [ccki_pkg::OCHAN_W-1:0] chan_out [NCH];

    for (genvar c = 0; c < NCH; c++)
    begin : g_chan
        logic [CW-1:0]    x_reg;
        logic [CW:0]      d_reg;
        logic [ACC_W-1:0] acc_reg, acc_next;
        logic [ACC_W-1:0] d_ext;

        assign d_ext = {{(ACC_W-CW-1){d_reg[CW]}}, d_reg};

        always_comb
        begin
            acc_next = acc_reg;
            if (ctrl.step)
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0} + (qbit ? d_ext : '0);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.load)
            begin
                x_reg   <= color_a[c*CW +: CW];
                d_reg   <= {1'b0, color_z[c*CW +: CW]} - {1'b0, color_a[c*CW +: CW]};
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end

        assign chan_out[c] = {x_reg, {CW{1'b0}}} + acc_reg[CW +: ccki_pkg::OCHAN_W];
    end

    assign blue  = chan_out[0];
    assign green = chan_out[1];
    assign red   = chan_out[2];

endmodule

FILE: bench/ccki_color_checker.sv
`timescale 1ns / 1ps

module ccki_color_checker #(
    parameter logic MODE_SAMPLE = 1'b1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  ccki_pkg::in_item_t            in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  ccki_pkg::out_item_t           out_data,
    input  logic                          cfg_we,
    input  logic [ccki_pkg::COUNT_W-1:0]  cfg_wdata,
    output int                            n_errors,
    output int                            n_pending
);
    import ccki_pkg::*;

    localparam int     MAXK     = MAX_KEYS_DEF;
    localparam int     TFB      = TIME_FRAC_BITS_DEF;
    localparam longint DAY_SPAN = longint'(DAY_UNITS) << TFB;

    logic [KTIME_W-1:0] key_time_mem  [MAXK];
    logic [COLOR_W-1:0] key_color_mem [MAXK];
    logic [COUNT_W-1:0] key_count_q;
    out_item_t          expected_colors [$];
    out_item_t          want;
    int                 err_count = 0;

    // floor((y-x)*frac/256) added to x in 8.8
    function automatic logic [OCHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] x,
                                                      input logic [CHAN_W-1:0] y,
                                                      input logic [FRAC_W-1:0] frac);
        longint d, f, part, acc;
        d = longint'(y) - longint'(x);
        f = longint'(frac);
        if (d >= 0)
            part = (d * f) >>> 8;
        else
            part = -(((-d) * f + 255) >>> 8);
        acc = longint'(x) * 256 + part;
        return acc[OCHAN_W-1:0];
    endfunction

    function automatic out_item_t color_at_time(input logic [STIME_W-1:0] at_in);
        int                 n, i, j, a, z;
        longint             seg_lo, seg_hi, at, q;
        logic [FRAC_W-1:0]  frac;
        logic               found;
        logic [COLOR_W-1:0] ca, cz;
        out_item_t          r;
        r     = '0;
        n     = (key_count_q > MAXK) ? MAXK : int'(key_count_q);
        a     = 0;
        z     = 0;
        frac  = '0;
        found = 1'b0;
        if (n == 0)
            return r;
        if (n >= 2) begin
            for (i = 0; i < n; i++) begin
                j      = (i + 1 == n) ? 0 : i + 1;
                seg_lo = longint'(key_time_mem[i]) << TFB;
                seg_hi = longint'(key_time_mem[j]) << TFB;
                at     = longint'(at_in);
                // closing segment runs past midnight back to key 0
                if (j == 0) begin
                    seg_hi = seg_hi + DAY_SPAN;
                    if (at < seg_lo)
                        at = at + DAY_SPAN;
                end
                if (!found && at >= seg_lo && at < seg_hi) begin
                    q     = ((at - seg_lo) << FRAC_W) / (seg_hi - seg_lo);
                    a     = i;
                    z     = j;
                    frac  = (q > 65535) ? '1 : q[FRAC_W-1:0];
                    found = 1'b1;
                end
            end
        end
        ca          = key_color_mem[a];
        cz          = key_color_mem[z];
        r.red       = blend_chan(ca[2*CHAN_W +: CHAN_W], cz[2*CHAN_W +: CHAN_W], frac);
        r.green     = blend_chan(ca[CHAN_W +: CHAN_W], cz[CHAN_W +: CHAN_W], frac);
        r.blue      = blend_chan(ca[0 +: CHAN_W], cz[0 +: CHAN_W], frac);
        r.first_key = a[INDEX_W-1:0];
        r.fraction  = frac;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    // config, then result, then request: a result never belongs to the
    // request taken on the same edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_count_q = '0;
            expected_colors.delete();
            n_pending <= 0;
        end
        else begin
            if (cfg_we)
                key_count_q = cfg_wdata;

            if (out_valid && !out_stall) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected result, expected none got %h", $time, out_data);
                    err_count++;
                end
                else begin
                    want = expected_colors.pop_front();
                    check_field("red", want.red, out_data.red);
                    check_field("green", want.green, out_data.green);
                    check_field("blue", want.blue, out_data.blue);
                    check_field("first_key", 16'(want.first_key), 16'(out_data.first_key));
                    check_field("fraction", want.fraction, out_data.fraction);
                end
            end

            if (in_valid && !in_stall) begin
                if (in_data.mode == MODE_SAMPLE) begin
                    expected_colors.push_back(color_at_time(in_data.sample_time));
                end
                else begin
                    key_time_mem[in_data.key_index]  = in_data.key_time;
                    key_color_mem[in_data.key_index] = in_data.key_color;
                end
            end

            n_pending <= expected_colors.size();
            n_errors  <= err_count;
        end
    end

endmodule

FILE: bench/cyclic_color_keyframe_interp_tb.sv
`timescale 1ns / 1ps

module cyclic_color_keyframe_interp_tb;
    import ccki_pkg::*;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_SAMPLE  = 1'b1;
    localparam int   NKEYS        = MAX_KEYS_DEF;
    localparam int   LATENCY_PAD  = 50;       // settle time after the checker drains
    localparam int   HOLD_CYCLES  = 300;      // long result-side hold-off
    localparam int   PHASE_ITEMS  = 330;
    localparam int   CYCLE_LIMIT  = 1000000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    in_item_t            in_data   = '0;
    logic                in_stall;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    int                  n_errors;
    int                  n_pending;

    // idle odds, percent per cycle, changed per phase
    int snd_idle_pct = 19;
    int rcv_idle_pct = 82;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_asked   = 0;
    int items_sent   = 0;
    int cycle_count  = 0;

    // last key time written to each slot, used to aim samples at key edges
    logic [KTIME_W-1:0] shadow_times [NKEYS];

    cyclic_color_keyframe_interp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ccki_color_checker #(
        .MODE_SAMPLE (MODE_SAMPLE)
    ) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cyclic_color_keyframe_interp_tb: errors");
            $finish;
        end
    end

    // Result side: random stall, or a long solid hold-off when asked.
    // The hold count lives here so the sender keeps offering meanwhile.
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    function automatic logic [COLOR_W-1:0] rand_color();
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            return '0;
        else if (p < 30)
            return '1;
        else
            return COLOR_W'($urandom);
    endfunction

    // every field random; the caller overrides the ones that matter
    function automatic in_item_t random_fill();
        in_item_t item;
        item.mode        = 1'($urandom);
        item.key_index   = INDEX_W'($urandom);
        item.key_time    = KTIME_W'($urandom);
        item.key_color   = COLOR_W'($urandom);
        item.sample_time = STIME_W'($urandom);
        return item;
    endfunction

    // Sample times: near key edges, anywhere in the day, past the day's end,
    // and the very last tick before midnight.
    function automatic logic [STIME_W-1:0] pick_sample_time(input int eff);
        int p, idx, kt;
        p = $urandom_range(0, 99);
        if (p < 30)
        begin
            idx = (eff > 1) ? int'($urandom_range(0, eff - 1)) : 0;
            kt  = int'(shadow_times[idx]) * 16 + int'($urandom_range(0, 2)) - 1;
            if (kt < 0)
                kt = 0;
            return kt[STIME_W-1:0];
        end
        else if (p < 85)
            return STIME_W'($urandom_range(0, DAY_UNITS * 16 - 1));
        else if (p < 95)
            return STIME_W'($urandom_range(0, 65535));
        else
            return STIME_W'(DAY_UNITS * 16 - 1);
    endfunction

    // One request: random gap first, then hold valid until accepted.
    // Returns on the edge that took it, valid still high.
    task automatic send_req(input in_item_t item);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [KTIME_W-1:0] kt,
                              input logic [COLOR_W-1:0] c);
        in_item_t item;
        item           = random_fill();
        item.mode      = MODE_WRITE;
        item.key_index = idx;
        item.key_time  = kt;
        item.key_color = c;
        shadow_times[idx] = kt;
        send_req(item);
    endtask

    task automatic send_sample(input logic [STIME_W-1:0] st);
        in_item_t item;
        item             = random_fill();
        item.mode        = MODE_SAMPLE;
        item.sample_time = st;
        send_req(item);
    endtask

    // any slot, any 12-bit time: breaks key ordering on purpose
    task automatic send_noise_write();
        logic [KTIME_W-1:0] kt;
        if ($urandom_range(0, 3) == 0)
            kt = KTIME_W'($urandom_range(0, 4095));
        else
            kt = KTIME_W'($urandom_range(0, DAY_UNITS - 1));
        send_write(INDEX_W'($urandom), kt, rand_color());
    endtask

    // Drop valid, wait until the checker holds no expectation, then let the
    // block finish anything that gives no result (a trailing key write).
    // n_pending is registered, so the first edge here already sees the
    // request taken on the edge before.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (LATENCY_PAD)
            @(posedge clk);
    endtask

    // only ever called with the block idle
    task automatic set_key_count(input logic [COUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // One round: pick a key count (extremes and the saturating range
    // included), load a key set, then a burst of samples with stray writes.
    task automatic run_round();
        int n, eff, i, t, hi, pick;
        wait_for_idle();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            n = 0;
        else if (pick < 16)
            n = 1;
        else if (pick < 28)
            n = NKEYS;
        else if (pick < 34)
            n = $urandom_range(NKEYS + 1, 31);
        else
            n = $urandom_range(2, NKEYS - 1);
        set_key_count(n[COUNT_W-1:0]);
        eff = (n > NKEYS) ? NKEYS : n;

        if ($urandom_range(0, 99) < 75)
        begin
            // well-formed: strictly increasing times, room left for every key
            t = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 100));
            if (eff < 2)
                send_write('0, t[KTIME_W-1:0], rand_color());
            for (i = 0; i < eff; i++)
            begin
                send_write(i[INDEX_W-1:0], t[KTIME_W-1:0], rand_color());
                if (i < eff - 1)
                begin
                    hi = (DAY_UNITS - 1 - t) / (eff - 1 - i);
                    t  = t + int'($urandom_range(1, hi));
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_noise_write();
        end

        repeat ($urandom_range(10, 25))
        begin
            if ($urandom_range(0, 99) < 8)
                send_noise_write();
            else
                send_sample(pick_sample_time(eff));
        end
    endtask

    initial
    begin
        int                 k, phase, target;
        logic [COLOR_W-1:0] c;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // no keys after reset: all-zero result, whatever the time
        send_sample('0);
        send_sample('1);

        // fill every slot before any count can read one; colors hit
        // black, white and opposite channel extremes
        for (k = 0; k < NKEYS; k++)
        begin
            case (k % 4)
                0:       c = '0;
                1:       c = '1;
                2:       c = 24'hFF00FF;
                default: c = rand_color();
            endcase
            send_write(k[INDEX_W-1:0], KTIME_W'(k * 180), c);
        end

        wait_for_idle();
        set_key_count(COUNT_W'(NKEYS));
        send_sample('0);                               // exactly on key 0
        send_sample(STIME_W'(180 * 16));               // exactly on key 1
        send_sample(STIME_W'(2700 * 16 + 8));          // last key, before midnight
        send_sample(STIME_W'(DAY_UNITS * 16 - 1));     // wrap segment, end of day
        send_sample('1);                               // past the day: no segment

        // single key: key 0 unblended
        wait_for_idle();
        set_key_count(COUNT_W'(1));
        send_sample(STIME_W'($urandom_range(0, 65535)));

        // count beyond the slot count saturates; fraction near one
        wait_for_idle();
        set_key_count('1);
        send_sample(STIME_W'(2700 * 16 - 1));

        // --- random phases ---
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 19;
                    rcv_idle_pct = 82;
                end
                1:
                begin
                    snd_idle_pct = 82;
                    rcv_idle_pct = 19;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    // back-pressure: results held while samples keep coming,
                    // so the block fills and stalls requests
                    wait_for_idle();
                    hold_asked <= hold_asked + 1;
                    repeat (12)
                        send_sample(pick_sample_time(NKEYS));
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_round();
        end

        wait_for_idle();
        if (n_errors == 0 && n_pending == 0)
            $display("cyclic_color_keyframe_interp_tb: clean");
        else
            $display("cyclic_color_keyframe_interp_tb: errors");
        $finish;
    end

endmodule

FILE: cyclic_color_keyframe_interp.f
hw/rtl/ccki_pkg.sv
hw/rtl/ccki_ram.sv
hw/rtl/ccki_div.sv
hw/rtl/ccki_blend.sv
hw/rtl/cyclic_color_keyframe_interp.sv
bench/ccki_color_checker.sv
bench/cyclic_color_keyframe_interp_tb.sv
